// ===== src/pga_pkg.sv =====
// Shared widths and payload types for the pairwise gravity acceleration pipeline.
package pga_pkg;

    localparam int PW   = 32;           // position, mass, constant and result width
    localparam int AW   = PW + 1;       // magnitude of a position difference
    localparam int SQW  = 2 * PW + 1;   // square of one difference
    localparam int D2W  = SQW + 1;      // sum of both squares
    localparam int RW   = 34;           // integer square root width
    localparam int GMW  = 2 * PW;       // product of constant and mass
    localparam int DENW = D2W + RW;     // d2 * d
    localparam int NUMW = GMW + AW + 8; // constant * mass * |delta| * 2^8
    localparam int QW   = PW + 1;       // quotient bits kept, top bit flags overflow

    // Values that ride alongside the square root pipeline.
    typedef struct packed {
        logic [AW-1:0]  adx;
        logic [AW-1:0]  ady;
        logic           sx;
        logic           sy;
        logic           co;
        logic [GMW-1:0] gm;
    } t_side;

    // Values that ride alongside the divider pipeline.
    typedef struct packed {
        logic sx;
        logic sy;
        logic co;
    } t_dside;

endpackage

// ===== src/pga_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module pga_isqrt import pga_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [D2W-1:0]   i_d2,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [RW-1:0]    o_root,
    output logic [D2W-1:0]   o_d2,
    output t_side            o_side
);

    localparam int TW = 2 * RW;

    logic            r_v    [0:RW];
    logic [TW-1:0]   r_rem  [0:RW];
    logic [RW-1:0]   r_root [0:RW];
    logic [D2W-1:0]  r_d2   [0:RW];
    t_side           r_side [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {{(TW-D2W){1'b0}}, i_d2};
            r_root[0] <= '0;
            r_d2[0]   <= i_d2;
            r_side[0] <= i_side;
        end
    end

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            localparam int B = RW - 1 - k;
            logic [TW-1:0] w_trial;

            // The remainder holds value minus root squared; the trial is the growth
            // of the square when this bit is set.
            assign w_trial = ({{(TW-RW){1'b0}}, r_root[k]} << (B + 1))
                           + ({{(TW-1){1'b0}}, 1'b1} << (2 * B));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_v[k+1] <= r_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_trial <= r_rem[k]) begin
                        r_rem[k+1]  <= r_rem[k] - w_trial;
                        r_root[k+1] <= r_root[k] | (RW'(1) << B);
                    end else begin
                        r_rem[k+1]  <= r_rem[k];
                        r_root[k+1] <= r_root[k];
                    end
                    r_d2[k+1]   <= r_d2[k];
                    r_side[k+1] <= r_side[k];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[RW];
    assign o_root  = r_root[RW];
    assign o_d2    = r_d2[RW];
    assign o_side  = r_side[RW];

endmodule

// ===== src/pga_div.sv =====
// Pipelined restoring division for both axes over a shared divisor.
module pga_div import pga_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUMW-1:0]  i_num_x,
    input  logic [NUMW-1:0]  i_num_y,
    input  logic [DENW-1:0]  i_den,
    input  t_dside           i_side,
    output logic             o_valid,
    output logic [QW-1:0]    o_q_x,
    output logic [QW-1:0]    o_q_y,
    output t_dside           o_side
);

    localparam int CW = DENW + QW;

    logic            r_v    [0:QW];
    logic [NUMW-1:0] r_rx   [0:QW];
    logic [NUMW-1:0] r_ry   [0:QW];
    logic [QW-1:0]   r_qx   [0:QW];
    logic [QW-1:0]   r_qy   [0:QW];
    logic [DENW-1:0] r_den  [0:QW];
    t_dside          r_side [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx[0]   <= i_num_x;
            r_ry[0]   <= i_num_y;
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            localparam int B = QW - 1 - k;
            logic [CW-1:0] w_sh;
            logic          w_gex;
            logic          w_gey;

            // The top stage only detects a quotient of 2^32 or more.
            assign w_sh  = {{(CW-DENW){1'b0}}, r_den[k]} << B;
            assign w_gex = {{(CW-NUMW){1'b0}}, r_rx[k]} >= w_sh;
            assign w_gey = {{(CW-NUMW){1'b0}}, r_ry[k]} >= w_sh;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_v[k+1] <= r_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rx[k+1]   <= w_gex ? r_rx[k] - w_sh[NUMW-1:0] : r_rx[k];
                    r_ry[k+1]   <= w_gey ? r_ry[k] - w_sh[NUMW-1:0] : r_ry[k];
                    r_qx[k+1]   <= r_qx[k] | ({{(QW-1){1'b0}}, w_gex} << B);
                    r_qy[k+1]   <= r_qy[k] | ({{(QW-1){1'b0}}, w_gey} << B);
                    r_den[k+1]  <= r_den[k];
                    r_side[k+1] <= r_side[k];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[QW];
    assign o_q_x   = r_qx[QW];
    assign o_q_y   = r_qy[QW];
    assign o_side  = r_side[QW];

endmodule

// ===== src/pairwise_gravity_acceleration.sv =====
// Top level of the pairwise gravity acceleration pipeline.
//
// This block takes one pair of bodies per transfer and returns the acceleration
// that the peer body causes on the self body, grav_const * peer_mass / d^2 along
// the direction from self to peer, in signed Q16.16 with saturation. One pair may
// be accepted in every cycle; each result passes through three front stages, a
// 35-stage square root made of an input register and one register per root bit,
// two multiply stages, a 34-stage divider made of an input register and one
// register per quotient bit, and the output register.
// The whole pipeline moves as one:
// it holds only while a finished result waits in the output register and the
// receiver stalls, and in that cycle the input stall is raised as well. Equal
// positions give zero acceleration with the coincident flag set. The mass of the
// self body cancels out and is ignored. grav_const is an unsigned Q8.24 value that
// resets to 1.0 and should only be written while no pair is in flight.
module pairwise_gravity_acceleration import pga_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [PW-1:0]        i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [PW-1:0] i_self_x,
    input  logic signed [PW-1:0] i_self_y,
    input  logic [PW-1:0]        i_self_mass,
    input  logic signed [PW-1:0] i_peer_x,
    input  logic signed [PW-1:0] i_peer_y,
    input  logic [PW-1:0]        i_peer_mass,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [PW-1:0] o_accel_x,
    output logic signed [PW-1:0] o_accel_y,
    output logic                 o_coincident,
    output logic                 o_saturated
);

    logic                 w_en;
    logic [PW-1:0]        r_grav;

    // Stage 1: differences, magnitudes and the constant times mass product.
    logic signed [AW-1:0] w_dx;
    logic signed [AW-1:0] w_dy;
    logic                 r1_v;
    t_side                r1_side;

    // Stage 2: squares of the differences.
    logic                 r2_v;
    logic [SQW-1:0]       r2_sqx;
    logic [SQW-1:0]       r2_sqy;
    t_side                r2_side;

    // Stage 3: squared distance.
    logic                 r3_v;
    logic [D2W-1:0]       r3_d2;
    t_side                r3_side;

    logic                 w_sq_v;
    logic [RW-1:0]        w_root;
    logic [D2W-1:0]       w_sq_d2;
    t_side                w_sq_side;

    // Stage 4: partial products of d2 * d and of gm * |delta|.
    logic                 r4_v;
    logic [D2W+RW-1:0]    r4_pd0;
    logic [D2W+RW-1:0]    r4_pd1;
    logic [D2W+RW-1:0]    r4_pd2;
    logic [PW+AW-1:0]     r4_px0;
    logic [PW+AW-1:0]     r4_px1;
    logic [PW+AW-1:0]     r4_py0;
    logic [PW+AW-1:0]     r4_py1;
    t_dside               r4_side;

    // Stage 5: full divisor and dividends.
    logic                 r5_v;
    logic [DENW-1:0]      r5_den;
    logic [NUMW-1:0]      r5_numx;
    logic [NUMW-1:0]      r5_numy;
    t_dside               r5_side;

    logic                 w_dv_v;
    logic [QW-1:0]        w_qx;
    logic [QW-1:0]        w_qy;
    t_dside               w_dv_side;

    logic                 w_satx;
    logic                 w_saty;
    logic                 r_out_valid;
    logic [PW-1:0]        r_ax;
    logic [PW-1:0]        r_ay;
    logic                 r_co;
    logic                 r_sat;

    // The pipeline advances unless a finished result is held by the receiver.
    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= PW'(32'h0100_0000);
        end else if (i_cfg_we) begin
            r_grav <= i_cfg_wdata;
        end
    end

    assign w_dx = AW'(i_peer_x) - AW'(i_self_x);
    assign w_dy = AW'(i_peer_y) - AW'(i_self_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= w_sq_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_side.adx <= w_dx[AW-1] ? AW'(-w_dx) : AW'(w_dx);
            r1_side.ady <= w_dy[AW-1] ? AW'(-w_dy) : AW'(w_dy);
            r1_side.sx  <= w_dx[AW-1];
            r1_side.sy  <= w_dy[AW-1];
            r1_side.co  <= (w_dx == '0) && (w_dy == '0);
            r1_side.gm  <= GMW'(r_grav) * GMW'(i_peer_mass);

            // A magnitude with its top bit set is exactly 2^32, whose square is 2^64.
            r2_sqx  <= r1_side.adx[AW-1] ? (SQW'(1) << (2 * PW))
                                        : SQW'(r1_side.adx[PW-1:0] * r1_side.adx[PW-1:0]);
            r2_sqy  <= r1_side.ady[AW-1] ? (SQW'(1) << (2 * PW))
                                        : SQW'(r1_side.ady[PW-1:0] * r1_side.ady[PW-1:0]);
            r2_side <= r1_side;

            r3_d2   <= D2W'(r2_sqx) + D2W'(r2_sqy);
            r3_side <= r2_side;

            r4_pd0  <= (D2W+RW)'(w_sq_d2[PW-1:0])     * (D2W+RW)'(w_root);
            r4_pd1  <= (D2W+RW)'(w_sq_d2[2*PW-1:PW])  * (D2W+RW)'(w_root);
            r4_pd2  <= (D2W+RW)'(w_sq_d2[D2W-1:2*PW]) * (D2W+RW)'(w_root);
            r4_px0  <= (PW+AW)'(w_sq_side.gm[PW-1:0])     * (PW+AW)'(w_sq_side.adx);
            r4_px1  <= (PW+AW)'(w_sq_side.gm[GMW-1:PW])   * (PW+AW)'(w_sq_side.adx);
            r4_py0  <= (PW+AW)'(w_sq_side.gm[PW-1:0])     * (PW+AW)'(w_sq_side.ady);
            r4_py1  <= (PW+AW)'(w_sq_side.gm[GMW-1:PW])   * (PW+AW)'(w_sq_side.ady);
            r4_side.sx <= w_sq_side.sx;
            r4_side.sy <= w_sq_side.sy;
            r4_side.co <= w_sq_side.co;

            r5_den  <= DENW'(r4_pd0) + (DENW'(r4_pd1) << PW) + (DENW'(r4_pd2) << (2 * PW));
            r5_numx <= (NUMW'(r4_px0) + (NUMW'(r4_px1) << PW)) << 8;
            r5_numy <= (NUMW'(r4_py0) + (NUMW'(r4_py1) << PW)) << 8;
            r5_side <= r4_side;
        end
    end

    pga_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_v),
        .i_d2    (r3_d2),
        .i_side  (r3_side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_d2    (w_sq_d2),
        .o_side  (w_sq_side)
    );

    pga_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_v),
        .i_num_x (r5_numx),
        .i_num_y (r5_numy),
        .i_den   (r5_den),
        .i_side  (r5_side),
        .o_valid (w_dv_v),
        .o_q_x   (w_qx),
        .o_q_y   (w_qy),
        .o_side  (w_dv_side)
    );

    // The top quotient bit means 2^32 or more. A negative result may reach 2^31.
    assign w_satx = w_qx[QW-1] || (w_dv_side.sx ? (w_qx[PW-1] && (w_qx[PW-2:0] != '0))
                                                 : w_qx[PW-1]);
    assign w_saty = w_qy[QW-1] || (w_dv_side.sy ? (w_qy[PW-1] && (w_qy[PW-2:0] != '0))
                                                 : w_qy[PW-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_co <= w_dv_side.co;
            if (w_dv_side.co) begin
                r_ax  <= '0;
                r_ay  <= '0;
                r_sat <= 1'b0;
            end else begin
                if (w_satx) begin
                    r_ax <= w_dv_side.sx ? PW'(32'h8000_0000) : PW'(32'h7FFF_FFFF);
                end else begin
                    r_ax <= w_dv_side.sx ? PW'(-w_qx[PW-1:0]) : w_qx[PW-1:0];
                end
                if (w_saty) begin
                    r_ay <= w_dv_side.sy ? PW'(32'h8000_0000) : PW'(32'h7FFF_FFFF);
                end else begin
                    r_ay <= w_dv_side.sy ? PW'(-w_qy[PW-1:0]) : w_qy[PW-1:0];
                end
                r_sat <= w_satx || w_saty;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_accel_x    = r_ax;
    assign o_accel_y    = r_ay;
    assign o_coincident = r_co;
    assign o_saturated  = r_sat;

    // The self mass cancels out of the acceleration.
    logic w_unused_mass;
    assign w_unused_mass = ^i_self_mass;

endmodule
